/* rtl/sseg_pkg.sv */
package sseg_pkg;

    localparam int DEPTH         = 64;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int KEY_WIDTH     = 31;
    localparam int OP_W          = 3;
    localparam int ST_W          = 2;
    localparam int IN_PAY_W      = 32;
    localparam int OUT_PAY_W     = 32;
    localparam int OUT_CNT_W     = 7;
    localparam int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W         = $clog2(DEPTH + 1);

    typedef logic [KEY_WIDTH-1:0]     t_key;
    typedef logic [PAYLOAD_WIDTH-1:0] t_pay;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [ST_W-1:0]          t_status;
    typedef logic [OP_W-1:0]          t_op;

    localparam t_op OP_INSERT = 3'd0;
    localparam t_op OP_POP    = 3'd1;
    localparam t_op OP_READ   = 3'd2;
    localparam t_op OP_DELETE = 3'd3;
    localparam t_op OP_CLEAR  = 3'd4;

    localparam t_status ST_DONE = 2'd0;
    localparam t_status ST_NONE = 2'd1;
    localparam t_status ST_DUP  = 2'd2;
    localparam t_status ST_FULL = 2'd3;

    typedef enum logic [1:0] {
        RD_MID,
        RD_POS,
        RD_SHIFT,
        RD_HEAD
    } t_rd_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRD,
        S_SCMP,
        S_POST,
        S_DUP_CHK,
        S_SH_RD,
        S_SH_WR,
        S_POP_WAIT,
        S_RD_WAIT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic    cap;
        logic    srch_init;
        logic    srch_step;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    sh_init;
        logic    sh_write;
        logic    ins_write;
        logic    pop_apply;
        logic    del_apply;
        logic    clr;
        logic    cur_set;
        logic    cur_clr;
        logic    st_set;
        t_status st_code;
        logic    st_data;
        logic    res_load;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic empty;
        logic full;
        logic cursor_set;
        logic srch_done;
        logic pos_lt_count;
        logic key_eq;
        logic sh_done;
        logic out_busy;
        t_cnt count;
    } t_dp_sts;

endpackage

/* rtl/sseg_if.sv */
interface sseg_op_if import sseg_pkg::*; ();
    logic                valid;
    logic                ready;
    t_op                 operation;
    t_key                entry_key;
    logic [IN_PAY_W-1:0] entry_payload;

    modport source (output valid, operation, entry_key, entry_payload, input ready);
    modport sink   (input valid, operation, entry_key, entry_payload, output ready);
endinterface

interface sseg_res_if import sseg_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_status              status;
    t_key                 out_key;
    logic [OUT_PAY_W-1:0] out_payload;
    logic [OUT_CNT_W-1:0] entry_count;

    modport source (output valid, status, out_key, out_payload, entry_count, input ready);
    modport sink   (input valid, status, out_key, out_payload, entry_count, output ready);
endinterface

/* rtl/sseg_dp.sv */
module sseg_dp import sseg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  t_op                  i_operation,
    input  t_key                 i_entry_key,
    input  logic [IN_PAY_W-1:0]  i_entry_payload,
    input  logic                 i_res_ready,
    output logic                 o_res_valid,
    output t_status              o_status,
    output t_key                 o_out_key,
    output logic [OUT_PAY_W-1:0] o_out_payload,
    output logic [OUT_CNT_W-1:0] o_entry_count
);

    localparam logic [CNT_W:0] DEPTH_SUM = (CNT_W + 1)'(DEPTH);

    function automatic t_addr phys_addr(input t_addr base, input t_cnt offs);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, base} + {1'b0, offs};
        if (sum >= DEPTH_SUM) begin
            sum = sum - DEPTH_SUM;
        end
        return sum[ADDR_W-1:0];
    endfunction

    t_key r_mem_key [DEPTH];
    t_pay r_mem_pay [DEPTH];

    t_op     r_op;
    t_key    r_target;
    t_pay    r_new_pay;
    t_cnt    r_lo;
    t_cnt    r_hi;
    t_cnt    r_sidx;
    t_key    r_rd_key;
    t_pay    r_rd_pay;
    t_status r_st;
    logic    r_st_data;
    t_status r_out_status;
    t_key    r_out_key;
    logic [OUT_PAY_W-1:0] r_out_pay;
    logic [OUT_CNT_W-1:0] r_out_cnt;

    t_addr r_head, n_head;
    t_cnt  r_count, n_count;
    t_key  r_cur_key, n_cur_key;
    logic  r_cur_set, n_cur_set;
    logic  r_out_valid, n_out_valid;

    logic [CNT_W:0] w_mid_sum;
    t_cnt           w_mid;
    logic           w_adv;
    t_cnt           w_rd_lidx;
    t_addr          w_rd_addr;
    t_addr          w_wr_addr;
    logic           w_wr_en;
    t_key           w_wr_key;
    t_pay           w_wr_pay;

    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_mid_sum[CNT_W:1];
    assign w_adv     = (r_op == OP_INSERT) ? (r_rd_key < r_target) : (r_rd_key <= r_target);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_MID:   w_rd_lidx = w_mid;
            RD_POS:   w_rd_lidx = r_lo;
            RD_SHIFT: w_rd_lidx = r_sidx - t_cnt'(1);
            default:  w_rd_lidx = '0;
        endcase
    end

    assign w_rd_addr = phys_addr(r_head, w_rd_lidx);
    assign w_wr_addr = phys_addr(r_head, i_cmd.sh_write ? r_sidx : r_lo);
    assign w_wr_en   = i_cmd.sh_write | i_cmd.ins_write;
    assign w_wr_key  = i_cmd.sh_write ? r_rd_key : r_target;
    assign w_wr_pay  = i_cmd.sh_write ? r_rd_pay : r_new_pay;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem_key[w_wr_addr] <= w_wr_key;
            r_mem_pay[w_wr_addr] <= w_wr_pay;
        end
        if (i_cmd.rd_en) begin
            r_rd_key <= r_mem_key[w_rd_addr];
            r_rd_pay <= r_mem_pay[w_rd_addr];
        end
    end

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_cur_key   = r_cur_key;
        n_cur_set   = r_cur_set;
        n_out_valid = r_out_valid;
        if (i_cmd.clr) begin
            n_head    = '0;
            n_count   = '0;
            n_cur_key = '0;
            n_cur_set = 1'b0;
        end
        if (i_cmd.pop_apply) begin
            n_head  = phys_addr(r_head, t_cnt'(1));
            n_count = r_count - t_cnt'(1);
        end
        if (i_cmd.del_apply) begin
            n_head  = phys_addr(r_head, r_lo);
            n_count = r_count - r_lo;
        end
        if (i_cmd.ins_write) begin
            n_count = r_count + t_cnt'(1);
        end
        if (i_cmd.cur_set) begin
            n_cur_key = r_rd_key;
            n_cur_set = 1'b1;
        end
        if (i_cmd.cur_clr) begin
            n_cur_key = '0;
            n_cur_set = 1'b0;
        end
        if (i_cmd.res_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_cur_key   <= '0;
            r_cur_set   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_cur_key   <= n_cur_key;
            r_cur_set   <= n_cur_set;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op      <= i_operation;
            r_target  <= (i_operation == OP_READ) ? r_cur_key : i_entry_key;
            r_new_pay <= t_pay'(i_entry_payload);
        end
        if (i_cmd.srch_init) begin
            r_lo <= '0;
            r_hi <= r_count;
        end
        if (i_cmd.srch_step) begin
            if (w_adv) begin
                r_lo <= w_mid + t_cnt'(1);
            end else begin
                r_hi <= w_mid;
            end
        end
        if (i_cmd.sh_init) begin
            r_sidx <= r_count;
        end
        if (i_cmd.sh_write) begin
            r_sidx <= r_sidx - t_cnt'(1);
        end
        if (i_cmd.st_set) begin
            r_st      <= i_cmd.st_code;
            r_st_data <= i_cmd.st_data;
        end
        if (i_cmd.res_load) begin
            r_out_status <= r_st;
            r_out_key    <= r_st_data ? r_rd_key : '0;
            r_out_pay    <= r_st_data ? OUT_PAY_W'(r_rd_pay) : '0;
            r_out_cnt    <= OUT_CNT_W'(r_count);
        end
    end

    assign o_sts.op           = r_op;
    assign o_sts.empty        = (r_count == '0);
    assign o_sts.full         = (r_count == t_cnt'(DEPTH));
    assign o_sts.cursor_set   = r_cur_set;
    assign o_sts.srch_done    = (r_lo == r_hi);
    assign o_sts.pos_lt_count = (r_lo < r_count);
    assign o_sts.key_eq       = (r_rd_key == r_target);
    assign o_sts.sh_done      = (r_sidx == r_lo);
    assign o_sts.out_busy     = r_out_valid & ~i_res_ready;
    assign o_sts.count        = r_count;

    assign o_res_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_key     = r_out_key;
    assign o_out_payload = r_out_pay;
    assign o_entry_count = r_out_cnt;

endmodule

/* rtl/sseg_ctrl.sv */
module sseg_ctrl import sseg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_op_valid,
    input  t_dp_sts i_sts,
    output logic    o_op_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_op_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_op_ready = 1'b1;
                if (i_op_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.op) inside
                    OP_INSERT, OP_DELETE: begin
                        o_cmd.srch_init = 1'b1;
                        n_state         = S_SRD;
                    end
                    OP_POP: begin
                        if (i_sts.empty) begin
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_NONE;
                            n_state       = S_FIN;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_HEAD;
                            n_state      = S_POP_WAIT;
                        end
                    end
                    OP_READ: begin
                        if (i_sts.empty) begin
                            o_cmd.cur_clr = 1'b1;
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_NONE;
                            n_state       = S_FIN;
                        end else begin
                            o_cmd.srch_init = 1'b1;
                            n_state         = i_sts.cursor_set ? S_SRD : S_POST;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.clr     = 1'b1;
                        o_cmd.st_set  = 1'b1;
                        o_cmd.st_code = ST_DONE;
                        n_state       = S_FIN;
                    end
                    default: begin
                        o_cmd.st_set  = 1'b1;
                        o_cmd.st_code = ST_NONE;
                        n_state       = S_FIN;
                    end
                endcase
            end
            S_SRD: begin
                if (i_sts.srch_done) begin
                    n_state = S_POST;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_MID;
                    n_state      = S_SCMP;
                end
            end
            S_SCMP: begin
                o_cmd.srch_step = 1'b1;
                n_state         = S_SRD;
            end
            S_POST: begin
                unique case (i_sts.op) inside
                    OP_INSERT: begin
                        if (i_sts.pos_lt_count) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_POS;
                            n_state      = S_DUP_CHK;
                        end else if (i_sts.full) begin
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_FULL;
                            n_state       = S_FIN;
                        end else begin
                            o_cmd.sh_init = 1'b1;
                            n_state       = S_SH_RD;
                        end
                    end
                    OP_READ: begin
                        if (!i_sts.pos_lt_count) begin
                            o_cmd.st_set  = 1'b1;
                            o_cmd.st_code = ST_NONE;
                            n_state       = S_FIN;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_POS;
                            n_state      = S_RD_WAIT;
                        end
                    end
                    default: begin
                        o_cmd.del_apply = 1'b1;
                        o_cmd.st_set    = 1'b1;
                        o_cmd.st_code   = ST_DONE;
                        n_state         = S_FIN;
                    end
                endcase
            end
            S_DUP_CHK: begin
                if (i_sts.key_eq) begin
                    o_cmd.st_set  = 1'b1;
                    o_cmd.st_code = ST_DUP;
                    n_state       = S_FIN;
                end else if (i_sts.full) begin
                    o_cmd.st_set  = 1'b1;
                    o_cmd.st_code = ST_FULL;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.sh_init = 1'b1;
                    n_state       = S_SH_RD;
                end
            end
            S_SH_RD: begin
                if (i_sts.sh_done) begin
                    o_cmd.ins_write = 1'b1;
                    o_cmd.st_set    = 1'b1;
                    o_cmd.st_code   = ST_DONE;
                    n_state         = S_FIN;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_SHIFT;
                    n_state      = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.sh_write = 1'b1;
                n_state        = S_SH_RD;
            end
            S_POP_WAIT: begin
                o_cmd.pop_apply = 1'b1;
                o_cmd.st_set    = 1'b1;
                o_cmd.st_code   = ST_DONE;
                o_cmd.st_data   = 1'b1;
                n_state         = S_FIN;
            end
            S_RD_WAIT: begin
                o_cmd.cur_set = 1'b1;
                o_cmd.st_set  = 1'b1;
                o_cmd.st_code = ST_DONE;
                o_cmd.st_data = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/sorted_segment_buffer.sv */
// Sorted segment buffer: holds up to DEPTH (key, descriptor) entries in ascending key order
// in a circular single-write, single-read entry memory with registered read data, so pops
// and prefix deletes only move the head pointer. Each operation beat yields one result beat
// carrying the entry count after the operation. Insert, delete and read-next with a cursor
// set run a binary search over the n entries held, of up to ceil(log2(n+1)) steps of one
// memory read and one compare each; read-next from the lowest entry skips it. Pop reads the
// head entry; clear, unknown codes, and pop or read-next on an empty store touch no entry.
// An insert that is neither a duplicate nor dropped as full moves the entries above its
// position up one slot each, a read and then a write through the one read port, before it
// writes the new entry. A new operation is taken while the previous result still waits on
// the output register; the next one then holds in its final cycle until that result beat
// is accepted. No clearing pass follows reset.
module sorted_segment_buffer import sseg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sseg_op_if.sink     i_op,
    sseg_res_if.source  o_res
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_op_ready;

    sseg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (i_op.valid),
        .i_sts      (w_sts),
        .o_op_ready (w_op_ready),
        .o_cmd      (w_cmd)
    );

    sseg_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_operation     (i_op.operation),
        .i_entry_key     (i_op.entry_key),
        .i_entry_payload (i_op.entry_payload),
        .i_res_ready     (o_res.ready),
        .o_res_valid     (o_res.valid),
        .o_status        (o_res.status),
        .o_out_key       (o_res.out_key),
        .o_out_payload   (o_res.out_payload),
        .o_entry_count   (o_res.entry_count)
    );

    assign i_op.ready = w_op_ready;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.count <= t_cnt'(DEPTH))
        else $error("entry count above depth");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.res_load |-> !w_sts.out_busy)
        else $error("result loaded over a stalled beat");

    a_shift_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.sh_write || w_cmd.ins_write) |-> !w_sts.full)
        else $error("entry write into a full store");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.res_load |=> o_res.valid)
        else $error("loaded result not presented");

endmodule

/* tb/tb_sorted_segment_buffer.sv */
`timescale 1ns / 100ps

module tb_sorted_segment_buffer;
    import sseg_pkg::*;

    localparam t_op  OP_UNUSED_FIRST = 3'd5;
    localparam t_op  OP_UNUSED_LAST  = 3'd7;
    localparam t_key KEY_MAX         = '1;
    localparam int   DRAIN_CYCLES    = 300;
    localparam int   MAX_REPORTS     = 10;

    typedef struct {
        t_status              status;
        t_key                 key;
        logic [OUT_PAY_W-1:0] payload;
        logic [OUT_CNT_W-1:0] count;
    } t_seg_result;

    logic i_clk;
    logic i_rst_n;

    sseg_op_if  op_bus ();
    sseg_res_if res_bus ();

    sorted_segment_buffer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_bus),
        .o_res   (res_bus)
    );

    t_key        held_keys[$];
    t_pay        held_pays[$];
    t_key        cursor_key;
    bit          cursor_valid;
    t_seg_result awaited_results[$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_request       = 0;
    int hold_left          = 0;
    int mismatch_count     = 0;
    int result_index       = 0;
    t_key key_window_base  = '0;

    always #1 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // drive ready; a requested hold-off stalls the result side for its full length
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            res_bus.ready = 1'b0;
        end else begin
            res_bus.ready = ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_seg_result want;
        if (i_rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("result beat %0d arrived with nothing pending: status %0d key %h",
                             result_index, res_bus.status, res_bus.out_key);
            end else begin
                want = awaited_results.pop_front();
                if (res_bus.status !== want.status || res_bus.out_key !== want.key ||
                    res_bus.out_payload !== want.payload || res_bus.entry_count !== want.count) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"result beat %0d: expected status %0d key %h payload %h ",
                                  "count %0d, got status %0d key %h payload %h count %0d"},
                                 result_index, want.status, want.key, want.payload, want.count,
                                 res_bus.status, res_bus.out_key, res_bus.out_payload,
                                 res_bus.entry_count);
                end
            end
            result_index++;
        end
    end

    task automatic compute_op_result(input t_op op, input t_key key,
                                     input logic [IN_PAY_W-1:0] pay);
        t_seg_result r;
        int          pos;
        r.status  = ST_DONE;
        r.key     = '0;
        r.payload = '0;
        pos       = 0;
        case (op)
            OP_INSERT: begin
                while (pos < held_keys.size() && held_keys[pos] < key) pos++;
                if (pos < held_keys.size() && held_keys[pos] == key) begin
                    r.status = ST_DUP;
                end else if (held_keys.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    held_keys.insert(pos, key);
                    held_pays.insert(pos, t_pay'(pay));
                end
            end
            OP_POP: begin
                if (held_keys.size() == 0) begin
                    r.status = ST_NONE;
                end else begin
                    r.key     = held_keys[0];
                    r.payload = held_pays[0];
                    held_keys.delete(0);
                    held_pays.delete(0);
                end
            end
            OP_READ: begin
                if (held_keys.size() == 0) begin
                    cursor_valid = 1'b0;
                    cursor_key   = '0;
                    r.status     = ST_NONE;
                end else begin
                    if (cursor_valid)
                        while (pos < held_keys.size() && held_keys[pos] <= cursor_key) pos++;
                    if (pos >= held_keys.size()) begin
                        r.status = ST_NONE;
                    end else begin
                        cursor_key   = held_keys[pos];
                        cursor_valid = 1'b1;
                        r.key        = held_keys[pos];
                        r.payload    = held_pays[pos];
                    end
                end
            end
            OP_DELETE: begin
                while (held_keys.size() > 0 && held_keys[0] <= key) begin
                    held_keys.delete(0);
                    held_pays.delete(0);
                end
            end
            OP_CLEAR: begin
                held_keys.delete();
                held_pays.delete();
                cursor_valid = 1'b0;
                cursor_key   = '0;
            end
            default: r.status = ST_NONE;
        endcase
        r.count = OUT_CNT_W'(held_keys.size());
        awaited_results.push_back(r);
    endtask

    task automatic send_op(input t_op op, input t_key key, input logic [IN_PAY_W-1:0] pay);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            op_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        op_bus.valid         = 1'b1;
        op_bus.operation     = op;
        op_bus.entry_key     = key;
        op_bus.entry_payload = pay;
        do @(posedge i_clk); while (op_bus.ready !== 1'b1);
        compute_op_result(op, key, pay);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        @(posedge i_clk);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    function automatic t_key pick_insert_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return t_key'($urandom);
        if (sel < 16 && held_keys.size() > 0)
            return held_keys[$urandom_range(held_keys.size() - 1)];
        return key_window_base + t_key'($urandom_range(511));
    endfunction

    function automatic t_key pick_delete_limit();
        int idx;
        if (held_keys.size() == 0 || $urandom_range(99) < 10)
            return t_key'($urandom);
        idx = $urandom_range((held_keys.size() > 4) ? 3 : held_keys.size() - 1);
        return held_keys[idx] - t_key'($urandom_range(1));
    endfunction

    task automatic test_empty_store();
        send_op(OP_POP, '0, '0);
        send_op(OP_READ, '0, '0);
        send_op(OP_DELETE, KEY_MAX, '1);
        for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
            send_op(t_op'(op), t_key'($urandom), $urandom);
    endtask

    task automatic test_key_extremes();
        send_op(OP_INSERT, KEY_MAX, '1);
        send_op(OP_INSERT, '0, '0);
        send_op(OP_INSERT, 31'h3FFF_FFFF, 32'hA5A5_A5A5);
        send_op(OP_INSERT, 31'h4000_0000, 32'h5A5A_5A5A);
        send_op(OP_INSERT, KEY_MAX, '0);
        send_op(OP_READ, '0, '0);
        send_op(OP_READ, '0, '0);
        send_op(OP_POP, '0, '0);
        send_op(OP_READ, '0, '0);
        send_op(OP_READ, '0, '0);
        send_op(OP_READ, '0, '0);
        send_op(OP_DELETE, 31'h3FFF_FFFF, '0);
        send_op(OP_DELETE, '0, '0);
        send_op(OP_READ, '0, '0);
        send_op(OP_CLEAR, '0, '0);
        send_op(OP_READ, '0, '0);
        send_op(OP_INSERT, 31'd123, $urandom);
        send_op(OP_READ, '0, '0);
        send_op(OP_POP, '0, '0);
        send_op(OP_READ, '0, '0);
        send_op(OP_INSERT, 31'd5, $urandom);
        send_op(OP_READ, '0, '0);
    endtask

    task automatic test_fill_to_full();
        send_op(OP_CLEAR, '0, '0);
        key_window_base = t_key'($urandom);
        while (held_keys.size() < DEPTH)
            send_op(OP_INSERT, pick_insert_key(), $urandom);
        send_op(OP_INSERT, held_keys[0] - 1'b1, $urandom);
        send_op(OP_INSERT, held_keys[DEPTH / 2], $urandom);
        repeat (3) send_op(OP_READ, '0, '0);
        send_op(OP_DELETE, KEY_MAX, '0);
        send_op(OP_READ, '0, '0);
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        hold_request = 400;
        repeat (40) send_op(OP_INSERT, pick_insert_key(), $urandom);
        repeat (10) send_op(OP_POP, '0, '0);
    endtask

    task automatic test_random_ops(input int count, input int sender_pct, input int receiver_pct);
        int   insert_pct;
        int   sel;
        t_op  op;
        t_key key;
        set_idling(sender_pct, receiver_pct);
        key_window_base = t_key'($urandom);
        for (int n = 0; n < count; n++) begin
            // alternate filling and draining blocks so the store reaches full and empty
            insert_pct = ((n / 96) % 2 == 0) ? 85 : 30;
            key        = '0;
            if ($urandom_range(99) < insert_pct) begin
                op  = OP_INSERT;
                key = pick_insert_key();
            end else begin
                sel = $urandom_range(99);
                if (sel < 35) begin
                    op = OP_POP;
                end else if (sel < 70) begin
                    op = OP_READ;
                end else if (sel < 92) begin
                    op  = OP_DELETE;
                    key = pick_delete_limit();
                end else if (sel < 95 && insert_pct < 50) begin
                    op              = OP_CLEAR;
                    key_window_base = t_key'($urandom);
                end else begin
                    op = t_op'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
                end
                if (op != OP_DELETE && $urandom_range(1))
                    key = t_key'($urandom);
            end
            send_op(op, key, $urandom);
        end
    endtask

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        op_bus.valid         = 1'b0;
        op_bus.operation     = OP_INSERT;
        op_bus.entry_key     = '0;
        op_bus.entry_payload = '0;
        res_bus.ready        = 1'b0;
        cursor_key           = '0;
        cursor_valid         = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_store();
        test_key_extremes();
        test_fill_to_full();
        test_backpressure();
        test_random_ops(280, 0, 0);
        test_random_ops(270, 84, 0);
        test_random_ops(270, 0, 84);
        test_random_ops(270, 33, 33);

        @(negedge i_clk);
        op_bus.valid = 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
